@@ rtl/kte_pkg.sv @@
// Shared constants, codes and types for the keyed table with age expiry.
`timescale 1ns / 1ps
package kte_pkg;

   localparam int TABLE_ENTRIES = 128;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

   localparam int MODE_W   = 3;
   localparam int KEY_W    = 24;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 7;
   localparam int RCNT_W   = 8;
   localparam int OCC_W    = 8;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 32;
   localparam int ENTRY_W     = KEY_W + TIME_W;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60000;

   typedef enum logic [MODE_W-1:0] {
      MODE_FIND   = 3'd0,
      MODE_UPSERT = 3'd1,
      MODE_TOUCH  = 3'd2,
      MODE_EXPIRE = 3'd3,
      MODE_CLEAR  = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_FOUND    = 3'd0,
      STAT_INSERTED = 3'd1,
      STAT_ABSENT   = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_DONE     = 3'd4
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] last_seen;
   } entry_type;

endpackage

@@ rtl/kte_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module kte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/keyed_table_with_age_expiry.sv @@
// Top level: compact key table with last-seen times and timeout sweep.
//
// Usage:
//  req_* : one request per transfer: mode, key_address, now_time_ms.
//  rsp_* : one result per request: status, slot_index, removed_count,
//          occupancy. Results come in request order.
//  csr_* : write of expiry_timeout_ms; always ready, write only while idle.
// Entries live in one RAM (key and last-seen time per slot); a lookup scan
// reads one slot per cycle, its data coming from the registered read port.
// Find/upsert/touch scan the valid slots in order until the key matches or
// all are read; an expire sweep checks each valid entry and fills a removed
// slot with the last entry. Clear and unused modes go straight to the
// result. The next request is taken once the current one has left for the
// output register.
// Reset empties the table and loads the timeout with 60000 ms; the RAM is
// not cleared, only the entry count.
// A stalled rsp_tready holds the result in the output register; one more
// request can then complete up to its hand-off and waits there.
`timescale 1ns / 1ps
module keyed_table_with_age_expiry (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: mode[2:0], key_address[26:3], now_time_ms[58:27], zero fill
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kte_pkg::REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: status[2:0], slot_index[9:3], removed_count[17:10],
   // occupancy[25:18], zero fill
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kte_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kte_pkg::TIME_W-1:0]      csr_data
);

   import kte_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SW_RD,
      S_SW_CHK,
      S_SW_MOVE,
      S_FIN
   } state_type;

   state_type           state_ff, state_in;
   logic [TIME_W-1:0]   timeout_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pend_addr_ff, pend_addr_in;
   logic [CNT_W-1:0]    removed_ff, removed_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   status_type          status_ff, status_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                wr_en, rd_en;
   logic [IDX_W-1:0]    wr_addr, rd_addr;
   entry_type           wr_entry, rd_entry;
   logic [ENTRY_W-1:0]  rd_word;
   logic [TIME_W-1:0]   age;
   logic                hit, rsp_free;

   kte_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry   = entry_type'(rd_word);
   assign age        = now_ff - rd_entry.last_seen;
   assign hit        = pend_ff && (rd_entry.key == key_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      removed_in   = removed_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      status_in    = status_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_entry     = '{key: key_ff, last_seen: now_ff};
      rd_en        = 1'b0;
      rd_addr      = issue_ff[IDX_W-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in    = req_tdata[MODE_W-1:0];
               key_in     = req_tdata[MODE_W +: KEY_W];
               now_in     = req_tdata[MODE_W+KEY_W +: TIME_W];
               issue_in   = '0;
               pend_in    = 1'b0;
               removed_in = '0;
               slot_in    = '0;
               status_in  = STAT_ABSENT;
               case (req_tdata[MODE_W-1:0])
                  MODE_FIND, MODE_UPSERT, MODE_TOUCH: state_in = S_SCAN;
                  MODE_EXPIRE: state_in = S_SW_RD;
                  MODE_CLEAR: begin
                     count_in  = '0;
                     status_in = STAT_DONE;
                     state_in  = S_FIN;
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               status_in = STAT_FOUND;
               slot_in   = pend_addr_ff;
               pend_in   = 1'b0;
               if (mode_ff == MODE_TOUCH) begin
                  wr_en = 1'b1;
               end
               state_in = S_FIN;
            end else if (issue_ff < count_ff) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = issue_ff[IDX_W-1:0];
               issue_in     = issue_ff + 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               state_in = S_FIN;
               if (mode_ff == MODE_UPSERT) begin
                  if (count_ff >= CNT_W'(TABLE_ENTRIES)) begin
                     status_in = STAT_FULL;
                  end else begin
                     wr_en     = 1'b1;
                     wr_addr   = count_ff[IDX_W-1:0];
                     slot_in   = count_ff[IDX_W-1:0];
                     count_in  = count_ff + 1'b1;
                     status_in = STAT_INSERTED;
                  end
               end
            end
         end
         S_SW_RD: begin
            if (issue_ff < count_ff) begin
               rd_en    = 1'b1;
               state_in = S_SW_CHK;
            end else begin
               status_in = STAT_DONE;
               state_in  = S_FIN;
            end
         end
         S_SW_CHK: begin
            if (issue_ff >= count_ff) begin
               status_in = STAT_DONE;
               state_in  = S_FIN;
            end else if (age > timeout_ff) begin
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(count_ff - 1'b1);
               state_in = S_SW_MOVE;
            end else begin
               issue_in = issue_ff + 1'b1;
               state_in = S_SW_RD;
            end
         end
         S_SW_MOVE: begin
            // moved entry stays on the read port and is checked next
            wr_en      = 1'b1;
            wr_addr    = issue_ff[IDX_W-1:0];
            wr_entry   = rd_entry;
            count_in   = count_ff - 1'b1;
            removed_in = removed_ff + 1'b1;
            state_in   = S_SW_CHK;
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_W'({OCC_W'(count_ff), RCNT_W'(removed_ff),
                                            SLOT_W'(slot_ff), status_ff});
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         timeout_ff   <= TIMEOUT_RESET;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
      end
      issue_ff     <= issue_in;
      pend_addr_ff <= pend_addr_in;
      removed_ff   <= removed_in;
      mode_ff      <= mode_in;
      key_ff       <= key_in;
      now_ff       <= now_in;
      status_ff    <= status_in;
      slot_ff      <= slot_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule
